[src/cutcf_pkg.sv]
// Shared constants, types and codes for the cut cell face flux correction block.
// No dependencies; imported by cutcf_muldiv and the top level.
package cutcf_pkg;

    localparam int NUM_FACES = 6;
    localparam int IDX_W     = (NUM_FACES > 1) ? $clog2(NUM_FACES) : 1;
    localparam int CNT_W     = $clog2(NUM_FACES + 1);
    localparam int FRAC_BITS = 16;
    localparam int WORK_W    = 48;     // signed working flux
    localparam int LIM_W     = 40;     // scaled limit
    localparam int SUM_W     = 35;     // sum, excess, left, per-face spread
    localparam int ROOM_W    = 44;     // room and total room
    localparam int RATIO_W   = 51;
    localparam int UNIT_W    = 64;     // shared unit operand width
    localparam int RES_W     = 96;     // shared unit result width
    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 64;

    localparam logic [2:0] MODE_DIR       = 3'd0;
    localparam logic [2:0] MODE_DIR2      = 3'd1;
    localparam logic [2:0] MODE_DIR_LIM   = 3'd2;
    localparam logic [2:0] MODE_DIR2_LIM  = 3'd3;
    localparam logic [2:0] MODE_SYM       = 3'd4;
    localparam logic [2:0] MODE_SYM_LIM   = 3'd5;

    localparam logic [LIM_W-1:0] LIM_CAP = {LIM_W{1'b1}};

    typedef enum logic [3:0] {
        ST_LOAD, ST_PREP, ST_SIGN, ST_FIX, ST_SUM, ST_RATIO, ST_SCALE,
        ST_ROOM, ST_LEFT, ST_SPREAD, ST_MIX, ST_SHARE, ST_OUT
    } t_state;

    typedef enum logic {
        UOP_MUL,
        UOP_DIV
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_req;

endpackage

[src/cutcf_muldiv.sv]
// Shared iterative multiply/divide unit: shift-add multiply, restoring divide.
// Depends on cutcf_pkg.
module cutcf_muldiv import cutcf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_unit_req         i_req,
    input  logic [UNIT_W-1:0] i_a,      // multiplicand or dividend
    input  logic [UNIT_W-1:0] i_b,      // multiplier (low 32 bits) or divisor
    output logic              o_done,
    output logic [RES_W-1:0]  o_result
);

    logic              r_busy;
    logic              r_done;
    t_unit_op          r_op;
    logic [6:0]        r_cnt;
    logic [UNIT_W:0]   r_acc;
    logic [UNIT_W-1:0] r_lo;
    logic [UNIT_W-1:0] r_opnd;

    logic [UNIT_W:0]   trial;
    logic              ge;
    logic [UNIT_W:0]   msum;

    always_comb begin
        trial = {r_acc[UNIT_W-1:0], r_lo[UNIT_W-1]};
        ge    = trial >= {1'b0, r_opnd};
        msum  = {1'b0, r_acc[UNIT_W-1:0]} + (r_lo[0] ? {1'b0, r_opnd} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == UOP_DIV) ? 7'(DIV_STEPS) : 7'(MUL_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_op   <= i_req.op;
            r_acc  <= '0;
            r_opnd <= (i_req.op == UOP_DIV) ? i_b : i_a;
            r_lo   <= (i_req.op == UOP_DIV) ? i_a : {32'd0, i_b[31:0]};
        end else if (r_busy) begin
            if (r_op == UOP_DIV) begin
                r_acc <= ge ? (trial - {1'b0, r_opnd}) : trial;
                r_lo  <= {r_lo[UNIT_W-2:0], ge};
            end else begin
                r_acc <= {1'b0, msum[UNIT_W:1]};
                r_lo  <= {msum[0], r_lo[UNIT_W-1:1]};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op == UOP_DIV) ? {32'd0, r_lo}
                                        : {r_acc[UNIT_W-1:0], r_lo[UNIT_W-1:32]};

endmodule

[src/cut_cell_face_flux_correction_core.sv]
// Top level of the cut cell face flux correction block: face store, sequencer,
// output stream. Depends on cutcf_pkg and cutcf_muldiv.
//
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready/tlast     tdata: flux, limit, total; tlast: last face
// m_axis    out  tvalid/tready/tlast     tdata: corrected flux; tuser: face, error
// cfg       in   i_cfg_we                i_cfg_wdata: correction mode
//
// Face requests are taken only while loading. The last face (tlast, or the
// sixth face) starts the sequencer: plain passes walk the faces in turn, and
// the shared unit does the ratio divide, one multiply per face, one divide for
// the unlimited spread, then a divide and multiply per face.
// Reset clears the sequencer, the face count and the mode. A stalled result
// holds until taken; no face request is taken until all results are out.
module cut_cell_face_flux_correction_core import cutcf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // face_flux[31:0], face_limit[62:32],
                                        // total_quantity[94:63], zero pad
    input  logic        s_axis_tlast,   // last_face
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // corrected_flux[31:0]
    output logic [3:0]  m_axis_tuser,   // face_number[2:0], mode_error[3]
    output logic        m_axis_tlast,   // last_result
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata
);

    // face store
    logic signed [31:0] r_flux [NUM_FACES];
    logic [30:0]        r_limit [NUM_FACES];
    logic signed [31:0] r_total;
    logic [IDX_W-1:0]   r_count;
    logic [2:0]         r_mode;

    // working values
    logic signed [WORK_W-1:0] r_w [NUM_FACES];
    logic [LIM_W-1:0]         r_sl [NUM_FACES];
    logic [ROOM_W-1:0]        r_room [NUM_FACES];
    logic [32:0]              r_pmax, r_nmax;
    logic                     r_pos;
    logic [SUM_W-1:0]         r_sum, r_excess, r_q, r_m;
    logic [RATIO_W-1:0]       r_ratio;
    logic [ROOM_W-1:0]        r_troom;
    logic [CNT_W-1:0]         r_unl;
    logic [16:0]              r_share;
    logic                     r_ph;
    logic                     r_wait;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx;

    t_unit_req         unit_req;
    logic [UNIT_W-1:0] unit_a, unit_b;
    logic              unit_done;
    logic [RES_W-1:0]  unit_res;

    logic accept, trigger, last_idx, lim_go, is_dir, out_take;
    logic signed [WORK_W-1:0] cur_w, x_ext, neg_w;
    logic [LIM_W-1:0]         sl_new;
    logic [SUM_W-1:0]         left;
    logic [32:0]              abs_total;

    cutcf_muldiv u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (unit_req),
        .i_a      (unit_a),
        .i_b      (unit_b),
        .o_done   (unit_done),
        .o_result (unit_res)
    );

    always_comb begin
        accept    = s_axis_tvalid && s_axis_tready;
        trigger   = accept && (s_axis_tlast || (r_count == IDX_W'(NUM_FACES - 1)));
        last_idx  = r_idx == IDX_W'(NUM_FACES - 1);
        out_take  = m_axis_tvalid && m_axis_tready;
        is_dir    = r_mode <= MODE_DIR2_LIM;
        lim_go    = (r_mode == MODE_DIR_LIM || r_mode == MODE_DIR2_LIM ||
                     r_mode == MODE_SYM_LIM) && (r_total != 32'sd0);
        cur_w     = r_w[r_idx];
        neg_w     = -cur_w;
        x_ext     = WORK_W'(r_flux[r_idx]);
        abs_total = r_total[31] ? (33'd0 - {r_total[31], r_total})
                                : {1'b0, r_total};
        left      = (ROOM_W'(r_excess) > r_troom) ? (r_excess - SUM_W'(r_troom)) : '0;
        // saturate the scaled limit once the product reaches 2^56
        sl_new    = (unit_res[RES_W-1:56] != '0) ? LIM_CAP : unit_res[55:16];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:   if (trigger) n_state = ST_PREP;
            ST_PREP:   if (last_idx) n_state = is_dir ? ST_SIGN
                                             : (lim_go ? ST_SUM : ST_OUT);
            ST_SIGN:   n_state = (r_pmax == '0 && r_nmax == '0)
                                 ? (lim_go ? ST_SUM : ST_OUT) : ST_FIX;
            ST_FIX:    if (last_idx) n_state = lim_go ? ST_SUM : ST_OUT;
            ST_SUM:    if (last_idx) n_state = ST_RATIO;
            ST_RATIO:  if (unit_done) n_state = ST_SCALE;
            ST_SCALE:  if (unit_done && last_idx) begin
                n_state = ((r_excess != '0) ||
                           (sl_new != '0 && cur_w > WORK_W'(sl_new))) ? ST_ROOM : ST_OUT;
            end
            ST_ROOM:   if (last_idx) n_state = ST_LEFT;
            ST_LEFT:   if (r_unl == '0) n_state = ST_MIX;
                       else if (unit_done) n_state = ST_SPREAD;
            ST_SPREAD: if (last_idx) n_state = ST_MIX;
            ST_MIX:    n_state = (r_troom == '0) ? ST_OUT : ST_SHARE;
            ST_SHARE:  if (unit_done && r_ph && last_idx) n_state = ST_OUT;
            ST_OUT:    if (out_take && last_idx) n_state = ST_LOAD;
            default:   n_state = ST_LOAD;
        endcase
    end

    // handshake and shared unit control
    always_comb begin
        s_axis_tready  = r_state == ST_LOAD;
        m_axis_tvalid  = r_state == ST_OUT;
        unit_req.start = 1'b0;
        unit_req.op    = UOP_DIV;
        unit_a         = '0;
        unit_b         = '0;
        unique case (r_state)
            ST_RATIO: begin
                unit_req.start = !r_wait;
                unit_a         = UNIT_W'({r_sum, 16'd0});
                unit_b         = UNIT_W'(abs_total);
            end
            ST_SCALE: begin
                unit_req.start = !r_wait;
                unit_req.op    = UOP_MUL;
                unit_a         = UNIT_W'(r_ratio);
                unit_b         = UNIT_W'(r_limit[r_idx]);
            end
            ST_LEFT: begin
                unit_req.start = !r_wait && (r_unl != '0);
                unit_a         = UNIT_W'(left);
                unit_b         = UNIT_W'(r_unl);
            end
            ST_SHARE: begin
                unit_req.start = !r_wait;
                if (!r_ph) begin
                    unit_a = UNIT_W'({r_room[r_idx], 16'd0});
                    unit_b = UNIT_W'(r_troom);
                end else begin
                    unit_req.op = UOP_MUL;
                    unit_a      = UNIT_W'(r_m);
                    unit_b      = UNIT_W'(r_share);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        if (cur_w > WORK_W'(32'sh7FFF_FFFF)) begin
            m_axis_tdata = 32'h7FFF_FFFF;
        end else if (cur_w < -WORK_W'(33'sh0_8000_0000)) begin
            m_axis_tdata = 32'h8000_0000;
        end else begin
            m_axis_tdata = cur_w[31:0];
        end
        m_axis_tuser = {(r_mode > MODE_SYM_LIM), 3'(r_idx)};
        m_axis_tlast = last_idx;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_mode  <= MODE_DIR;
            r_idx   <= '0;
            r_wait  <= 1'b0;
            r_ph    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_mode <= i_cfg_wdata;
            if (accept) r_count <= trigger ? '0 : r_count + IDX_W'(1);
            if (unit_req.start) r_wait <= 1'b1;
            else if (unit_done) r_wait <= 1'b0;
            if (r_state == ST_SHARE && unit_done) r_ph <= !r_ph;
            // each pass walks the faces from zero
            if (n_state != r_state) begin
                r_idx <= '0;
            end else begin
                unique case (r_state)
                    ST_PREP, ST_FIX, ST_SUM, ST_ROOM, ST_SPREAD:
                        r_idx <= r_idx + IDX_W'(1);
                    ST_SCALE: if (unit_done) r_idx <= r_idx + IDX_W'(1);
                    ST_SHARE: if (unit_done && r_ph) r_idx <= r_idx + IDX_W'(1);
                    ST_OUT:   if (out_take) r_idx <= r_idx + IDX_W'(1);
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flux[r_count]  <= s_axis_tdata[31:0];
            r_limit[r_count] <= s_axis_tdata[62:32];
            r_total          <= s_axis_tdata[94:63];
            if (trigger) begin
                // faces never loaded count as zero
                for (int i = 0; i < NUM_FACES; i++) begin
                    if (IDX_W'(i) > r_count) begin
                        r_flux[i]  <= '0;
                        r_limit[i] <= '0;
                    end
                end
                r_pmax <= '0;
                r_nmax <= '0;
            end
        end
        case (r_state)
            ST_PREP: begin
                case (r_mode)
                    MODE_DIR, MODE_DIR_LIM: r_w[r_idx] <= -x_ext;
                    MODE_SYM, MODE_SYM_LIM: r_w[r_idx] <= x_ext[WORK_W-1] ? -x_ext : x_ext;
                    default:                r_w[r_idx] <= x_ext;
                endcase
                if (r_mode == MODE_DIR || r_mode == MODE_DIR_LIM) begin
                    if (-x_ext > $signed(WORK_W'(r_pmax))) r_pmax <= 33'(-x_ext);
                    if (x_ext > $signed(WORK_W'(r_nmax)))  r_nmax <= 33'(x_ext);
                end else begin
                    if (x_ext > $signed(WORK_W'(r_pmax)))  r_pmax <= 33'(x_ext);
                    if (-x_ext > $signed(WORK_W'(r_nmax))) r_nmax <= 33'(-x_ext);
                end
                r_sum <= '0;
            end
            ST_SIGN: begin
                // dominance at one tenth: n < p/10 <=> 10(n+1) <= p
                if (({4'd0, r_pmax} + 37'd1) * 37'd10 <= {4'd0, r_nmax}) r_pos <= 1'b0;
                else if (({4'd0, r_nmax} + 37'd1) * 37'd10 <= {4'd0, r_pmax}) r_pos <= 1'b1;
                else r_pos <= r_total > 32'sd0;
            end
            ST_FIX: begin
                if (r_pos) r_w[r_idx] <= (cur_w > 0) ? cur_w : '0;
                else       r_w[r_idx] <= (neg_w > 0) ? neg_w : '0;
            end
            ST_SUM: begin
                r_sum    <= r_sum + SUM_W'(cur_w);
                r_excess <= '0;
            end
            ST_RATIO: if (unit_done) r_ratio <= unit_res[RATIO_W-1:0];
            ST_SCALE: if (unit_done) begin
                r_sl[r_idx] <= sl_new;
                if (sl_new != '0 && cur_w > WORK_W'(sl_new)) begin
                    r_excess   <= r_excess + SUM_W'(cur_w - WORK_W'(sl_new));
                    r_w[r_idx] <= WORK_W'(sl_new);
                end
                r_troom <= '0;
                r_unl   <= '0;
            end
            ST_ROOM: begin
                if (r_sl[r_idx] != '0) begin
                    r_room[r_idx] <= ROOM_W'(r_sl[r_idx]) - ROOM_W'(cur_w);
                    r_troom       <= r_troom + ROOM_W'(r_sl[r_idx]) - ROOM_W'(cur_w);
                end else begin
                    r_room[r_idx] <= '0;
                    if (cur_w != '0) r_unl <= r_unl + CNT_W'(1);
                end
            end
            ST_LEFT: if (unit_done) r_q <= unit_res[SUM_W-1:0];
            ST_SPREAD: begin
                if (r_sl[r_idx] == '0 && cur_w != '0) begin
                    r_room[r_idx] <= ROOM_W'(r_q);
                    r_troom       <= r_troom + ROOM_W'(r_q);
                end
            end
            ST_MIX: r_m <= (ROOM_W'(r_excess) < r_troom) ? r_excess : SUM_W'(r_troom);
            ST_SHARE: if (unit_done) begin
                if (!r_ph) r_share <= unit_res[16:0];
                else       r_w[r_idx] <= cur_w + WORK_W'(unit_res[63:16]);
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    // never take a face while results are being delivered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("face request taken during result delivery");

    // the shared unit is started only once per operation
    a_unit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unit_req.start |=> !unit_req.start)
        else $error("shared unit started twice");

    // a delivered last result returns the block to loading
    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && m_axis_tlast) |=> (s_axis_tready && r_count == '0))
        else $error("block did not return to loading after a cell");
`endif

endmodule

[sim/cut_cell_face_flux_correction_core_tb.sv]
// Testbench for cut_cell_face_flux_correction_core: streams face requests, predicts the
// corrected fluxes per cell, checks them in order. Depends on cutcf_pkg and the RTL.
module cut_cell_face_flux_correction_core_tb;
    import cutcf_pkg::*;

    typedef struct packed {
        logic [31:0] flux;
        logic [2:0]  face;
        logic        err;
        logic        last;
    } t_flux_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_wdata = '0;

    int n_fail = 0;
    int n_cells = 0;
    int n_res = 0;

    class flux_scoreboard;
        logic signed [63:0] flux_q [NUM_FACES];
        logic [63:0]        lim_q  [NUM_FACES];
        int unsigned        count;
        logic [2:0]         mode;
        t_flux_res          pending [$];

        function new();
            count = 0;
            mode  = MODE_DIR;
        endfunction

        function void correct(logic signed [63:0] total);
            logic signed [63:0] f [NUM_FACES];
            logic signed [63:0] pmax, nmax, s, r;
            logic [63:0] v [NUM_FACES], lim [NUM_FACES], room [NUM_FACES];
            logic [63:0] sum, at, ratio, excess, troom, left, m, share;
            int unsigned unl;
            logic pos, err;
            pmax = 0; nmax = 0; err = 0;
            for (int i = 0; i < NUM_FACES; i++) begin
                f[i] = flux_q[i];
                if (mode == MODE_DIR || mode == MODE_DIR_LIM) f[i] = -f[i];
            end
            if (mode <= MODE_DIR2_LIM) begin
                for (int i = 0; i < NUM_FACES; i++) begin
                    if (f[i] > pmax) pmax = f[i];
                    if (-f[i] > nmax) nmax = -f[i];
                end
                if (pmax != 0 || nmax != 0) begin
                    pos = total > 0;
                    if (nmax < pmax / 10) pos = 1;
                    if (pmax < nmax / 10) pos = 0;
                    for (int i = 0; i < NUM_FACES; i++) begin
                        s = pos ? f[i] : -f[i];
                        f[i] = (s > 0) ? s : 0;
                    end
                end
            end else if (mode == MODE_SYM || mode == MODE_SYM_LIM) begin
                for (int i = 0; i < NUM_FACES; i++) if (f[i] < 0) f[i] = -f[i];
            end else begin
                err = 1;
            end
            if (total != 0 && (mode == MODE_DIR_LIM || mode == MODE_DIR2_LIM
                               || mode == MODE_SYM_LIM)) begin
                sum = 0; excess = 0; troom = 0; unl = 0;
                for (int i = 0; i < NUM_FACES; i++) begin
                    v[i] = f[i]; sum += v[i]; room[i] = 0;
                end
                at = (total < 0) ? -total : total;
                ratio = (sum << FRAC_BITS) / at;
                for (int i = 0; i < NUM_FACES; i++) begin
                    if (lim_q[i] == 0 || ratio == 0) lim[i] = 0;
                    else if (ratio > ((64'd1 << 56) - 1) / lim_q[i]) lim[i] = (64'd1 << 40) - 1;
                    else lim[i] = (lim_q[i] * ratio) >> FRAC_BITS;
                    if (lim[i] != 0 && v[i] > lim[i]) begin
                        excess += v[i] - lim[i];
                        v[i] = lim[i];
                    end
                end
                if (excess != 0) begin
                    for (int i = 0; i < NUM_FACES; i++) begin
                        if (lim[i] != 0) begin
                            room[i] = lim[i] - v[i];
                            troom += room[i];
                        end else if (v[i] != 0) unl++;
                    end
                    left = (excess > troom) ? excess - troom : 0;
                    if (unl != 0)
                        for (int i = 0; i < NUM_FACES; i++)
                            if (lim[i] == 0 && v[i] != 0) begin
                                room[i] = left / unl;
                                troom += room[i];
                            end
                    if (troom != 0) begin
                        m = (excess < troom) ? excess : troom;
                        for (int i = 0; i < NUM_FACES; i++) begin
                            share = (room[i] << FRAC_BITS) / troom;
                            v[i] += (share * m) >> FRAC_BITS;
                        end
                    end
                end
                for (int i = 0; i < NUM_FACES; i++) f[i] = v[i];
            end
            for (int i = 0; i < NUM_FACES; i++) begin
                t_flux_res e;
                r = f[i];
                if (r > 64'sd2147483647) r = 64'sd2147483647;
                if (r < -64'sd2147483648) r = -64'sd2147483648;
                e.flux = r[31:0];
                e.face = i[2:0];
                e.err  = err;
                e.last = (i == NUM_FACES - 1);
                pending.push_back(e);
            end
        endfunction

        // Note one accepted face request.
        function void note_face(logic [95:0] d, logic lst);
            int unsigned p;
            p = (count >= NUM_FACES) ? 0 : count;
            flux_q[p] = $signed(d[31:0]);
            lim_q[p]  = {33'd0, d[62:32]};
            if (!lst && p < NUM_FACES - 1) begin
                count = p + 1;
                return;
            end
            for (int i = p + 1; i < NUM_FACES; i++) begin
                flux_q[i] = 0; lim_q[i] = 0;
            end
            count = 0;
            correct($signed(d[94:63]));
        endfunction

        function int check_result(t_flux_res a);
            t_flux_res e;
            int bad;
            bad = 0;
            if (pending.size() == 0) begin
                $error("unexpected result flux=%h", a.flux);
                return 1;
            end
            e = pending.pop_front();
            if (a.flux !== e.flux) begin
                $error("corrected_flux exp %h got %h", e.flux, a.flux); bad = 1;
            end
            if (a.face !== e.face) begin
                $error("face_number exp %0d got %0d", e.face, a.face); bad = 1;
            end
            if (a.err !== e.err) begin
                $error("mode_error exp %0d got %0d", e.err, a.err); bad = 1;
            end
            if (a.last !== e.last) begin
                $error("last_result exp %0d got %0d", e.last, a.last); bad = 1;
            end
            return bad;
        endfunction
    endclass

    flux_scoreboard sb = new();

    cut_cell_face_flux_correction_core u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: stall on its own pattern, with quiet stretches.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_fail += sb.check_result({m_axis_tdata, m_axis_tuser[2:0], m_axis_tuser[3],
                                       m_axis_tlast});
            n_res++;
        end
        if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic logic [31:0] rand_flux();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom_range(0, 32'h0003_0000);
            4: return -$urandom_range(0, 32'h0003_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_limit();
        case ($urandom_range(0, 5))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom_range(1, 32'h0002_0000));
            default: return 31'($urandom);
        endcase
    endfunction

    // Send one face request; the sender idles in bursts.
    int burst_left = 0;
    task automatic send_face(logic [31:0] fl, logic [30:0] lm, logic [31:0] tot, logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, tot, lm, fl};
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_face({1'b0, tot, lm, fl}, lst);
    endtask

    task automatic send_cell(int nf, logic [31:0] tot);
        for (int i = 0; i < nf; i++)
            send_face(rand_flux(), rand_limit(), tot, i == nf - 1);
        n_cells++;
    endtask

    // Hold until the block is drained, then write the mode.
    task automatic set_mode(logic [2:0] md);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= md;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.mode = md;
    endtask

    initial begin
        int items;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: extremes, all modes, early and missing last face.
        for (int md = 0; md < 8; md++) begin
            set_mode(md[2:0]);
            send_face(32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 1'b0);
            send_face(32'h7FFF_FFFF, 31'd0, 32'h0, 1'b1);
        end
        set_mode(MODE_DIR2_LIM);
        for (int i = 0; i < NUM_FACES; i++) send_face(32'd0, 31'h100, 32'h10000, 1'b0);
        send_face(32'h0001_0000, 31'h8000, 32'h0001_0000, 1'b0);
        for (int i = 0; i < 5; i++) send_face(32'h0001_0000, 31'h8000, 32'h0, 1'b0);
        items = 0;
        while (items < 320) begin
            set_mode(3'($urandom_range(0, 7)));
            repeat ($urandom_range(2, 6)) begin
                int nf;
                nf = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : NUM_FACES;
                send_cell(nf, ($urandom_range(0, 7) == 0) ? 32'd0 : rand_flux());
                items += nf;
            end
        end
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Covered %0d random cells plus directed cells in all eight modes, %0d results.",
                 n_cells, n_res);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
